[design/per_process_descriptor_byte_fifos_assert.svh]
// Assertion macros for the per-process descriptor FIFO block.
// Used by the port checker; depends on nothing else.
`ifndef PER_PROCESS_DESCRIPTOR_BYTE_FIFOS_ASSERT_SVH
`define PER_PROCESS_DESCRIPTOR_BYTE_FIFOS_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/dpf_pkg.sv]
// Shared constants for the per-process descriptor FIFO block.
// Used by the top level, the byte store, the checker and the testbench; depends on nothing.
package dpf_pkg;

   localparam int NUM_PROCS_DEF = 16;
   localparam int SLOTS_DEF     = 8;
   localparam int CAPACITY_DEF  = 64;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 7;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_PUSH   = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;
   localparam logic [1:0] KIND_RESET  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOSLOT = 3'd4;

   localparam logic [BYTE_W-1:0] FIRST_FD_RESET = 8'd3;

endpackage

[design/dpf_row_mem.sv]
// Per-process slot table: in-use and fresh bits for every slot of a process.
// A row whose valid bit is clear reads as the post-reset row. Uses dpf_pkg-free logic only.
module dpf_row_mem #(
   parameter int ROW_AW = 4,
   parameter int ROW_W  = 16,
   parameter logic [ROW_W-1:0] INIT_ROW = '0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ROW_AW-1:0] rd_addr,
   input  logic              wr_en,
   input  logic              clr_en,
   input  logic [ROW_AW-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_data,
   output logic [ROW_W-1:0]  rd_data
);

   localparam int ROWS = 1 << ROW_AW;

   logic [ROW_W-1:0] mem [ROWS];
   logic [ROWS-1:0]  valid_ff;
   logic [ROW_W-1:0] data_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (clr_en) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : INIT_ROW;

endmodule

[design/dpf_ptr_mem.sv]
// Pointer memory: read pointer, write pointer and byte count of every FIFO.
// Single write port, single registered read port; depends on nothing.
module dpf_ptr_mem #(
   parameter int AW = 7,
   parameter int DW = 19
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [1 << AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/dpf_byte_mem.sv]
// Byte store holding the contents of every FIFO, addressed by FIFO and pointer.
// Single write port, single registered read port; uses dpf_pkg for the byte width.
module dpf_byte_mem #(
   parameter int AW = 13
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [dpf_pkg::BYTE_W-1:0]    wr_data,
   output logic [dpf_pkg::BYTE_W-1:0]    rd_data
);

   logic [dpf_pkg::BYTE_W-1:0] mem [1 << AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/per_process_descriptor_byte_fifos.sv]
// Top level of the per-process descriptor FIFO block: control sequencer and memories.
// Depends on dpf_pkg, dpf_row_mem, dpf_ptr_mem and dpf_byte_mem.
//
// Usage: each item on the req_ channel carries one operation (create, push, pop or
// process reset) for one process. Exactly one result item leaves on the rsp_ channel
// for every accepted item, in order. The csr_ channel writes the descriptor base,
// which is always accepted and must only be written while the block is idle.
// The accepting edge reads the slot table and pointer memories; the sequencer then
// updates them and accesses the byte store, and loads the result register once that
// register is free. The block handles one item at a time: it takes no new item until
// it has loaded the result of the last one into the result register.
// A new item is taken while the previous result still waits on rsp_ready; the
// sequencer holds its finished result until the result register frees up.
// After the synchronous reset every process has slots zero to two in use and empty,
// and the base is three; the reset takes effect at once, with no clearing pass.
module per_process_descriptor_byte_fifos #(
   parameter int NUM_PROCS = dpf_pkg::NUM_PROCS_DEF,
   parameter int SLOTS     = dpf_pkg::SLOTS_DEF,
   parameter int CAPACITY  = dpf_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dpf_pkg::BYTE_W-1:0]    csr_first_fd_number,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_kind,
   input  logic [3:0]                    req_process,
   input  logic [dpf_pkg::BYTE_W-1:0]    req_descriptor,
   input  logic [dpf_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dpf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dpf_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic [dpf_pkg::BYTE_W-1:0]    rsp_new_descriptor,
   output logic [dpf_pkg::FILL_W-1:0]    rsp_fill_level,
   output logic                          rsp_ready_res
);

   localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int PTR_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int PE_W   = 2 * PTR_W + CNT_W;
   localparam int ROW_W  = 2 * SLOTS;
   localparam int FIFO_AW = PROC_W + SLOT_W;
   localparam int BYTE_AW = FIFO_AW + PTR_W;
   localparam logic [SLOTS-1:0] INIT_USE = SLOTS'(7);
   localparam logic [ROW_W-1:0] INIT_ROW = {{SLOTS{1'b1}}, INIT_USE};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DATA
   } state_type;

   state_type                         state_ff, state_in;
   logic [dpf_pkg::BYTE_W-1:0]        base_ff;
   logic [1:0]                        kind_ff, kind_in;
   logic [PROC_W-1:0]                 proc_ff, proc_in;
   logic [SLOT_W-1:0]                 slot_ff, slot_in;
   logic [dpf_pkg::BYTE_W-1:0]        data_ff, data_in;
   logic                              proc_ok_ff, proc_ok_in;
   logic                              desc_ok_ff, desc_ok_in;
   logic [dpf_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [dpf_pkg::BYTE_W-1:0]        newd_ff, newd_in;
   logic [CNT_W-1:0]                  fill_ff, fill_in;
   logic                              pop_ok_ff, pop_ok_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dpf_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [dpf_pkg::BYTE_W-1:0]        rsp_byte_ff, rsp_byte_in;
   logic [dpf_pkg::BYTE_W-1:0]        rsp_newd_ff, rsp_newd_in;
   logic [dpf_pkg::FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;
   logic                              rsp_rdy_ff, rsp_rdy_in;

   logic                              accept;
   logic [dpf_pkg::BYTE_W-1:0]        desc_off;
   logic [ROW_W-1:0]                  row_q;
   logic [PE_W-1:0]                   ptr_q;
   logic [dpf_pkg::BYTE_W-1:0]        byte_q;
   logic [SLOTS-1:0]                  in_use, fresh, slot_bit, free_bit;
   logic                              free_found;
   logic [SLOT_W-1:0]                 free_idx;
   logic [CNT_W-1:0]                  cnt;
   logic [PTR_W-1:0]                  wp, rp, wp_next, rp_next;
   logic                              row_wr, row_clr, ptr_wr, byte_wr, byte_rd;
   logic [ROW_W-1:0]                  row_wdata;
   logic [PE_W-1:0]                   ptr_wdata;
   logic [BYTE_AW-1:0]                byte_waddr, byte_raddr;
   logic                              load_rsp;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign desc_off  = req_descriptor - base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= dpf_pkg::FIRST_FD_RESET;
      end else if (csr_valid) begin
         base_ff <= csr_first_fd_number;
      end
   end

   dpf_row_mem #(
      .ROW_AW   (PROC_W),
      .ROW_W    (ROW_W),
      .INIT_ROW (INIT_ROW)
   ) u_rows (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (PROC_W'(req_process)),
      .wr_en   (row_wr),
      .clr_en  (row_clr),
      .wr_addr (proc_ff),
      .wr_data (row_wdata),
      .rd_data (row_q)
   );

   dpf_ptr_mem #(
      .AW (FIFO_AW),
      .DW (PE_W)
   ) u_ptrs (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr ({PROC_W'(req_process), SLOT_W'(desc_off)}),
      .wr_en   (ptr_wr),
      .wr_addr ({proc_ff, slot_ff}),
      .wr_data (ptr_wdata),
      .rd_data (ptr_q)
   );

   dpf_byte_mem #(
      .AW (BYTE_AW)
   ) u_bytes (
      .clock   (clock),
      .rd_en   (byte_rd),
      .rd_addr (byte_raddr),
      .wr_en   (byte_wr),
      .wr_addr (byte_waddr),
      .wr_data (data_ff),
      .rd_data (byte_q)
   );

   always_comb begin
      in_use   = row_q[SLOTS-1:0];
      fresh    = row_q[ROW_W-1:SLOTS];
      slot_bit = SLOTS'(1) << slot_ff;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
      free_bit = SLOTS'(1) << free_idx;
      if ((fresh & slot_bit) != '0) begin
         cnt = '0;
         wp  = '0;
         rp  = '0;
      end else begin
         cnt = ptr_q[CNT_W-1:0];
         wp  = ptr_q[CNT_W +: PTR_W];
         rp  = ptr_q[CNT_W + PTR_W +: PTR_W];
      end
      wp_next = (wp == PTR_W'(CAPACITY - 1)) ? '0 : wp + PTR_W'(1);
      rp_next = (rp == PTR_W'(CAPACITY - 1)) ? '0 : rp + PTR_W'(1);
      byte_waddr = {proc_ff, slot_ff, wp};
      byte_raddr = {proc_ff, slot_ff, rp};
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      proc_in       = proc_ff;
      slot_in       = slot_ff;
      data_in       = data_ff;
      proc_ok_in    = proc_ok_ff;
      desc_ok_in    = desc_ok_ff;
      status_in     = status_ff;
      newd_in       = newd_ff;
      fill_in       = fill_ff;
      pop_ok_in     = pop_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_newd_in   = rsp_newd_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_rdy_in    = rsp_rdy_ff;
      row_wr        = 1'b0;
      row_clr       = 1'b0;
      row_wdata     = row_q;
      ptr_wr        = 1'b0;
      ptr_wdata     = {rp, wp, cnt};
      byte_wr       = 1'b0;
      byte_rd       = 1'b0;
      load_rsp      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               proc_in    = PROC_W'(req_process);
               slot_in    = SLOT_W'(desc_off);
               data_in    = req_data_byte;
               proc_ok_in = 32'(req_process) < NUM_PROCS;
               desc_ok_in = (req_descriptor >= base_ff) &&
                            (desc_off < dpf_pkg::BYTE_W'(SLOTS));
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in = dpf_pkg::STAT_OK;
            newd_in   = '0;
            fill_in   = '0;
            pop_ok_in = 1'b0;
            if (!proc_ok_ff) begin
               status_in = dpf_pkg::STAT_BAD;
            end else begin
               unique case (kind_ff)
                  dpf_pkg::KIND_RESET: begin
                     row_clr = 1'b1;
                  end
                  dpf_pkg::KIND_CREATE: begin
                     if (!free_found) begin
                        status_in = dpf_pkg::STAT_NOSLOT;
                     end else begin
                        row_wr    = 1'b1;
                        row_wdata = {fresh | free_bit, in_use | free_bit};
                        newd_in   = base_ff + dpf_pkg::BYTE_W'(free_idx);
                     end
                  end
                  default: begin
                     if (!desc_ok_ff || (in_use & slot_bit) == '0) begin
                        status_in = dpf_pkg::STAT_BAD;
                     end else if (kind_ff == dpf_pkg::KIND_PUSH) begin
                        if (cnt >= CNT_W'(CAPACITY)) begin
                           status_in = dpf_pkg::STAT_FULL;
                           fill_in   = cnt;
                        end else begin
                           byte_wr   = 1'b1;
                           ptr_wr    = 1'b1;
                           ptr_wdata = {rp, wp_next, cnt + CNT_W'(1)};
                           row_wr    = 1'b1;
                           row_wdata = {fresh & ~slot_bit, in_use};
                           fill_in   = cnt + CNT_W'(1);
                        end
                     end else begin
                        if (cnt == '0) begin
                           status_in = dpf_pkg::STAT_EMPTY;
                        end else begin
                           byte_rd   = 1'b1;
                           pop_ok_in = 1'b1;
                           ptr_wr    = 1'b1;
                           ptr_wdata = {rp_next, wp, cnt - CNT_W'(1)};
                           row_wr    = 1'b1;
                           row_wdata = {fresh & ~slot_bit, in_use};
                           fill_in   = cnt - CNT_W'(1);
                        end
                     end
                  end
               endcase
            end
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_byte_in   = pop_ok_ff ? byte_q : '0;
               rsp_newd_in   = newd_ff;
               rsp_fill_in   = dpf_pkg::FILL_W'(fill_ff);
               rsp_rdy_in    = (fill_ff != '0);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      proc_ff    <= proc_in;
      slot_ff    <= slot_in;
      data_ff    <= data_in;
      proc_ok_ff <= proc_ok_in;
      desc_ok_ff <= desc_ok_in;
      status_ff  <= status_in;
      newd_ff    <= newd_in;
      fill_ff    <= fill_in;
      pop_ok_ff  <= pop_ok_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_newd_ff   <= rsp_newd_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_rdy_ff    <= rsp_rdy_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_byte      = rsp_byte_ff;
   assign rsp_new_descriptor = rsp_newd_ff;
   assign rsp_fill_level     = rsp_fill_ff;
   assign rsp_ready_res      = rsp_rdy_ff;

endmodule

[design/dpf_checker.sv]
// Port-level checker for the per-process descriptor FIFO block, with its bind.
// Depends on dpf_pkg and per_process_descriptor_byte_fifos_assert.svh.
`include "per_process_descriptor_byte_fifos_assert.svh"

module dpf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dpf_pkg::STATUS_W-1:0]  rsp_status,
   input logic [dpf_pkg::BYTE_W-1:0]    rsp_read_byte,
   input logic [dpf_pkg::BYTE_W-1:0]    rsp_new_descriptor,
   input logic [dpf_pkg::FILL_W-1:0]    rsp_fill_level,
   input logic                          rsp_ready_res
);

   `DPF_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "block took an item while busy")

   `DPF_ASSERT_NOW(bad_reports_nothing, clock, reset, rsp_valid && rsp_status == dpf_pkg::STAT_BAD, rsp_fill_level == '0 && !rsp_ready_res && rsp_read_byte == '0, "bad descriptor item reports a fill level")

   `DPF_ASSERT_NOW(byte_only_on_ok, clock, reset, rsp_valid && rsp_status != dpf_pkg::STAT_OK, rsp_read_byte == '0 && rsp_new_descriptor == '0, "failed item returns data")

   `DPF_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_read_byte), "stalled result changed")

endmodule

bind per_process_descriptor_byte_fifos dpf_checker u_dpf_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for per_process_descriptor_byte_fifos.
// Holds its own model of the descriptor FIFO table and checks every result item
// in order; depends on dpf_pkg and the block's top level only.
module testbench;

   localparam int BYTE_W   = dpf_pkg::BYTE_W;
   localparam int STATUS_W = dpf_pkg::STATUS_W;
   localparam int FILL_W   = dpf_pkg::FILL_W;
   localparam int NPROC = dpf_pkg::NUM_PROCS_DEF;
   localparam int NSLOT = dpf_pkg::SLOTS_DEF;
   localparam int DEPTH = dpf_pkg::CAPACITY_DEF;
   localparam int NFIFO = NPROC * NSLOT;
   localparam int PHASE_ITEMS = 220;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT = 3000;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   read_byte;
      logic [BYTE_W-1:0]   new_descriptor;
      logic [FILL_W-1:0]   fill_level;
      logic                ready_res;
   } fifo_reply_type;

   class fd_fifo_tracker_type;
      logic [BYTE_W-1:0] fd_base;
      logic [NSLOT-1:0]  slot_used [NPROC];
      int                rd_ptr [NFIFO];
      int                wr_ptr [NFIFO];
      int                level [NFIFO];
      logic [BYTE_W-1:0] byte_mem [NFIFO*DEPTH];
      fifo_reply_type    replies_due [$];
      int                replies_seen;
      int                failures;

      function new();
         fd_base = dpf_pkg::FIRST_FD_RESET;
         replies_seen = 0;
         failures = 0;
         for (int p = 0; p < NPROC; p++) begin
            clear_table(p);
         end
      endfunction

      function void set_base(logic [BYTE_W-1:0] value);
         fd_base = value;
      endfunction

      function void clear_fifo(int f);
         rd_ptr[f] = 0;
         wr_ptr[f] = 0;
         level[f] = 0;
      endfunction

      function void clear_table(int p);
         for (int i = 0; i < NSLOT; i++) begin
            clear_fifo(p * NSLOT + i);
         end
         slot_used[p] = '0;
         slot_used[p][2:0] = 3'b111;
      endfunction

      function void note_request(logic [1:0] kind, logic [3:0] proc,
                                 logic [BYTE_W-1:0] desc, logic [BYTE_W-1:0] data);
         fifo_reply_type r;
         int slot;
         int f;
         bit found;
         r.status = dpf_pkg::STAT_OK;
         r.read_byte = '0;
         r.new_descriptor = '0;
         r.fill_level = '0;
         r.ready_res = 1'b0;
         found = 0;
         if (int'(proc) >= NPROC) begin
            r.status = dpf_pkg::STAT_BAD;
         end else begin
            case (kind)
               dpf_pkg::KIND_RESET: begin
                  clear_table(proc);
               end
               dpf_pkg::KIND_CREATE: begin
                  r.status = dpf_pkg::STAT_NOSLOT;
                  for (int i = 0; i < NSLOT; i++) begin
                     if (!found && !slot_used[proc][i]) begin
                        found = 1;
                        slot_used[proc][i] = 1'b1;
                        clear_fifo(proc * NSLOT + i);
                        r.new_descriptor = fd_base + BYTE_W'(i);
                        r.status = dpf_pkg::STAT_OK;
                     end
                  end
               end
               default: begin
                  slot = int'(desc) - int'(fd_base);
                  if (slot < 0 || slot >= NSLOT || !slot_used[proc][slot]) begin
                     r.status = dpf_pkg::STAT_BAD;
                  end else begin
                     f = proc * NSLOT + slot;
                     if (kind == dpf_pkg::KIND_PUSH) begin
                        if (level[f] >= DEPTH) begin
                           r.status = dpf_pkg::STAT_FULL;
                        end else begin
                           byte_mem[f * DEPTH + wr_ptr[f]] = data;
                           wr_ptr[f] = (wr_ptr[f] + 1) % DEPTH;
                           level[f]++;
                        end
                     end else begin
                        if (level[f] == 0) begin
                           r.status = dpf_pkg::STAT_EMPTY;
                        end else begin
                           r.read_byte = byte_mem[f * DEPTH + rd_ptr[f]];
                           rd_ptr[f] = (rd_ptr[f] + 1) % DEPTH;
                           level[f]--;
                        end
                     end
                     r.fill_level = FILL_W'(level[f]);
                     r.ready_res = (level[f] > 0);
                  end
               end
            endcase
         end
         replies_due.push_back(r);
      endfunction

      function void report(string what, int unsigned want, int unsigned got);
         failures++;
         if (failures <= 10) begin
            $display("mismatch on %s at result %0d: expected %0d, got %0d",
                     what, replies_seen, want, got);
         end
      endfunction

      function void check_reply(fifo_reply_type got);
         fifo_reply_type want;
         replies_seen++;
         if (replies_due.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("result item %0d arrived with no expectation waiting",
                        replies_seen);
            end
         end else begin
            want = replies_due.pop_front();
            if (got.status !== want.status) begin
               report("status", want.status, got.status);
            end
            if (got.read_byte !== want.read_byte) begin
               report("read_byte", want.read_byte, got.read_byte);
            end
            if (got.new_descriptor !== want.new_descriptor) begin
               report("new_descriptor", want.new_descriptor, got.new_descriptor);
            end
            if (got.fill_level !== want.fill_level) begin
               report("fill_level", want.fill_level, got.fill_level);
            end
            if (got.ready_res !== want.ready_res) begin
               report("ready_res", want.ready_res, got.ready_res);
            end
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_valid;
   logic                csr_ready;
   logic [BYTE_W-1:0]   csr_first_fd_number;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_kind;
   logic [3:0]          req_process;
   logic [BYTE_W-1:0]   req_descriptor;
   logic [BYTE_W-1:0]   req_data_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic [BYTE_W-1:0]   rsp_new_descriptor;
   logic [FILL_W-1:0]   rsp_fill_level;
   logic                rsp_ready_res;

   fd_fifo_tracker_type tracker = new();
   int burst_left = 0;
   int idle_cycles = 0;

   per_process_descriptor_byte_fifos dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_first_fd_number (csr_first_fd_number),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_process         (req_process),
      .req_descriptor      (req_descriptor),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_new_descriptor  (rsp_new_descriptor),
      .rsp_fill_level      (rsp_fill_level),
      .rsp_ready_res       (rsp_ready_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(logic [1:0] kind, logic [3:0] proc,
                               logic [BYTE_W-1:0] desc, logic [BYTE_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_process <= proc;
      req_descriptor <= desc;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(kind, proc, desc, data);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_base(logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_first_fd_number <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_base(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_reply('{rsp_status, rsp_read_byte, rsp_new_descriptor,
                               rsp_fill_level, rsp_ready_res});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("per_process_descriptor_byte_fifos verification failed");
            $finish;
         end
      end
   end

   initial begin
      int mode_left;
      int mode;
      bit held;
      mode_left = 0;
      mode = 0;
      held = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!held && tracker.replies_seen >= 250) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 99) < 70);
               default: rsp_ready <= ($urandom_range(0, 99) < 25);
            endcase
         end
      end
   end

   initial begin
      logic [BYTE_W-1:0] bases [5];
      traffic_mode_type  traffic;
      int                seg_left;
      logic [3:0]        focus_proc;
      int                focus_slot;
      int                r;
      logic [1:0]        kind;
      logic [3:0]        proc;
      logic [BYTE_W-1:0] desc;
      logic [BYTE_W-1:0] base;

      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_first_fd_number <= dpf_pkg::FIRST_FD_RESET;
      req_valid <= 1'b0;
      req_kind <= dpf_pkg::KIND_CREATE;
      req_process <= '0;
      req_descriptor <= '0;
      req_data_byte <= '0;
      bases[0] = dpf_pkg::FIRST_FD_RESET;
      bases[1] = 8'd0;
      bases[2] = 8'd247;
      bases[3] = BYTE_W'($urandom_range(0, 247));
      bases[4] = dpf_pkg::FIRST_FD_RESET;
      traffic = MODE_MIXED;
      seg_left = 0;
      focus_proc = '0;
      focus_slot = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            wait_drained();
            repeat (5) @(posedge clock);
            write_base(bases[ph]);
         end
         base = bases[ph];
         if (ph == 0) begin
            // Empty pop, extreme bytes through one FIFO, and bad descriptors of every sort.
            send_request(dpf_pkg::KIND_POP, 4'd0, 8'd3, 8'd0);
            send_request(dpf_pkg::KIND_PUSH, 4'd0, 8'd3, 8'h00);
            send_request(dpf_pkg::KIND_PUSH, 4'd0, 8'd3, 8'hFF);
            send_request(dpf_pkg::KIND_POP, 4'd0, 8'd3, 8'hFF);
            send_request(dpf_pkg::KIND_POP, 4'd0, 8'd3, 8'h00);
            send_request(dpf_pkg::KIND_PUSH, 4'd0, 8'd2, 8'h5A);
            send_request(dpf_pkg::KIND_PUSH, 4'd0, 8'd0, 8'h5A);
            send_request(dpf_pkg::KIND_PUSH, 4'd0, 8'd11, 8'h5A);
            send_request(dpf_pkg::KIND_POP, 4'd0, 8'd6, 8'h00);
            send_request(dpf_pkg::KIND_PUSH, 4'd0, 8'd255, 8'hFF);
            // Exhaust the free slots of the last process, then reset its table.
            repeat (6) send_request(dpf_pkg::KIND_CREATE, 4'd15, 8'hFF, 8'hFF);
            send_request(dpf_pkg::KIND_PUSH, 4'd15, 8'd10, 8'hA5);
            send_request(dpf_pkg::KIND_PUSH, 4'd15, 8'd3, 8'h3C);
            send_request(dpf_pkg::KIND_RESET, 4'd15, 8'd10, 8'h00);
            send_request(dpf_pkg::KIND_POP, 4'd15, 8'd10, 8'h00);
            send_request(dpf_pkg::KIND_POP, 4'd15, 8'd3, 8'h00);
            send_request(dpf_pkg::KIND_CREATE, 4'd15, 8'd0, 8'h00);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (seg_left == 0) begin
               traffic = traffic_mode_type'($urandom_range(0, 2));
               seg_left = (traffic == MODE_FILL) ? 140 : 70;
               focus_proc = 4'($urandom_range(0, NPROC - 1));
               focus_slot = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 2)
                                                         : $urandom_range(3, NSLOT - 1);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            case (traffic)
               MODE_FILL: kind = (r < 5) ? dpf_pkg::KIND_CREATE :
                                 (r < 92) ? dpf_pkg::KIND_PUSH : dpf_pkg::KIND_POP;
               MODE_DRAIN: kind = (r < 5) ? dpf_pkg::KIND_CREATE :
                                  (r < 6) ? dpf_pkg::KIND_RESET :
                                  (r < 14) ? dpf_pkg::KIND_PUSH : dpf_pkg::KIND_POP;
               default: kind = (r < 12) ? dpf_pkg::KIND_CREATE :
                               (r < 15) ? dpf_pkg::KIND_RESET :
                               (r < 60) ? dpf_pkg::KIND_PUSH : dpf_pkg::KIND_POP;
            endcase
            proc = ($urandom_range(0, 99) < 88) ? focus_proc : 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            if (r < 78) begin
               desc = base + BYTE_W'(focus_slot);
            end else if (r < 93) begin
               desc = base + BYTE_W'($urandom_range(0, NSLOT - 1));
            end else if (r < 96) begin
               desc = ($urandom_range(0, 1) == 0) ? base - 8'd1 : base + BYTE_W'(NSLOT);
            end else begin
               desc = BYTE_W'($urandom_range(0, 255));
            end
            send_request(kind, proc, desc, BYTE_W'($urandom_range(0, 255)));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.replies_due.size() != 0) begin
         tracker.failures += tracker.replies_due.size();
         $display("%0d expected result items never arrived", tracker.replies_due.size());
      end
      if (tracker.failures == 0) begin
         $display("per_process_descriptor_byte_fifos verification clean");
      end else begin
         $display("per_process_descriptor_byte_fifos verification failed");
      end
      $finish;
   end
endmodule

[per_process_descriptor_byte_fifos.f]
+incdir+design
design/dpf_pkg.sv
design/dpf_row_mem.sv
design/dpf_ptr_mem.sv
design/dpf_byte_mem.sv
design/per_process_descriptor_byte_fifos.sv
design/dpf_checker.sv
tb/testbench.sv
